>>> rtl/stq_pkg.sv
// Shared types and codes for the sorted timer queue.
package stq_pkg;

    localparam int DL_W  = 32;
    localparam int ID_W  = 8;
    localparam int ST_W  = 2;
    localparam int POS_W = 4;
    localparam int CNT_W = 5;

    // Result status codes
    localparam logic [ST_W-1:0] ST_DONE      = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

    // Request modes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    typedef struct packed {
        logic            mode;
        logic [DL_W-1:0] deadline;
        logic [ID_W-1:0] timer_id;
    } req_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [POS_W-1:0] position;
        logic [CNT_W-1:0] entry_count;
    } rsp_t;

    // One table slot
    typedef struct packed {
        logic [DL_W-1:0] deadline;
        logic [ID_W-1:0] timer_id;
    } entry_t;

endpackage

>>> rtl/stq_store.sv
// Slot memory: one write port, one read port with registered read data.
module stq_store #(
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  stq_pkg::entry_t          wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output stq_pkg::entry_t          rdata
);
    import stq_pkg::*;

    entry_t mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data valid the cycle after the address
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/sorted_timer_queue.sv
// Per request: scan to the slot, shift the rest, write (insert only); a full table answers
// without a scan.
// A new beat is taken only once the previous response is issued; a stalled response holds the sequencer.
// Scan and shift share the slot memory read port, one slot a cycle; the compare unit serves the scan.
// Reset: rst_n clears the count, sequencer and response valid; slot contents are not cleared.
// Top level: sorted table of timers with insert and delete by id.
module sorted_timer_queue #(
    parameter int DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  stq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output stq_pkg::rsp_t rsp
);
    import stq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_WRITE  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]      state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   scan_reg, scan_next;
    logic            dv_reg, dv_next;
    logic [IW-1:0]   chk_reg, chk_next;
    logic [CW-1:0]   mv_reg, mv_next;
    logic [IW-1:0]   src_reg, src_next;
    logic [CW-1:0]   pos_reg, pos_next;
    logic [ST_W-1:0] st_reg, st_next;
    req_t            item_reg, item_next;
    rsp_t            rsp_reg, rsp_next;
    logic            rsp_valid_reg, rsp_valid_next;

    logic            mem_we;
    logic [IW-1:0]   mem_waddr;
    entry_t          mem_wdata;
    logic            mem_re;
    logic [IW-1:0]   mem_raddr;
    entry_t          mem_rdata;

    logic            hit;
    logic [CW-1:0]   found_pos;

    stq_store #(.DEPTH(DEPTH)) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Compare unit used by the scan: checks the slot just read against the item
    always_comb
    begin
        if (item_reg.mode == MODE_DELETE)
        begin
            hit = dv_reg && (mem_rdata.timer_id == item_reg.timer_id);
        end
        else
        begin
            hit = dv_reg && !(mem_rdata.deadline < item_reg.deadline);
        end
        found_pos = hit ? CW'(chk_reg) : count_reg;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        dv_next        = 1'b0;
        chk_next       = chk_reg;
        mv_next        = mv_reg;
        src_next       = src_reg;
        pos_next       = pos_reg;
        st_next        = st_reg;
        item_next      = item_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = mem_rdata;
        mem_re         = 1'b0;
        mem_raddr      = '0;

        // response taken downstream
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next = req;
                    scan_next = '0;
                    if (req.mode == MODE_INSERT && count_reg == CW'(DEPTH))
                    begin
                        st_next    = ST_FULL;
                        pos_next   = '0;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (hit || (!dv_reg && scan_reg == count_reg))
                begin
                    if (item_reg.mode == MODE_DELETE && !hit)
                    begin
                        st_next    = ST_NOT_FOUND;
                        pos_next   = '0;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        st_next  = ST_DONE;
                        pos_next = found_pos;
                        if (item_reg.mode == MODE_INSERT)
                        begin
                            mv_next  = count_reg - found_pos;
                            src_next = IW'(count_reg - CW'(1));
                        end
                        else
                        begin
                            mv_next  = count_reg - found_pos - CW'(1);
                            src_next = IW'(found_pos + CW'(1));
                        end
                        state_next = S_SHIFT;
                    end
                end
                else if (scan_reg != count_reg)
                begin
                    // issue the next slot read
                    mem_re    = 1'b1;
                    mem_raddr = scan_reg[IW-1:0];
                    dv_next   = 1'b1;
                    chk_next  = scan_reg[IW-1:0];
                    scan_next = scan_reg + CW'(1);
                end
            end

            S_SHIFT:
            begin
                // move the slot read last cycle one place up or down
                if (dv_reg)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata;
                    if (item_reg.mode == MODE_INSERT)
                    begin
                        mem_waddr = chk_reg + IW'(1);
                    end
                    else
                    begin
                        mem_waddr = chk_reg - IW'(1);
                    end
                end
                if (mv_reg != '0)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = src_reg;
                    dv_next   = 1'b1;
                    chk_next  = src_reg;
                    mv_next   = mv_reg - CW'(1);
                    if (item_reg.mode == MODE_INSERT)
                    begin
                        src_next = src_reg - IW'(1);
                    end
                    else
                    begin
                        src_next = src_reg + IW'(1);
                    end
                end
                else if (!dv_reg)
                begin
                    if (item_reg.mode == MODE_INSERT)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = S_FINISH;
                    end
                end
            end

            S_WRITE:
            begin
                mem_we             = 1'b1;
                mem_waddr          = pos_reg[IW-1:0];
                mem_wdata.deadline = item_reg.deadline;
                mem_wdata.timer_id = item_reg.timer_id;
                count_next         = count_reg + CW'(1);
                state_next         = S_FINISH;
            end

            S_FINISH:
            begin
                // wait for the response register to be free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.status      = st_reg;
                    rsp_next.position    = POS_W'(pos_reg);
                    rsp_next.entry_count = CNT_W'(count_reg);
                    rsp_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            dv_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dv_reg        <= dv_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        chk_reg  <= chk_next;
        mv_reg   <= mv_next;
        src_reg  <= src_next;
        pos_reg  <= pos_next;
        st_reg   <= st_next;
        item_reg <= item_next;
        rsp_reg  <= rsp_next;
    end

endmodule

>>> rtl/stq_checker.sv
// Port-level checks for the sorted timer queue, bound to the top level.
module stq_checker #(
    parameter int DEPTH = 16
) (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input stq_pkg::rsp_t rsp
);
    import stq_pkg::*;

    // a beat taken keeps the block busy for at least the next cycle
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("req_ready high right after a request beat");

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // only defined status codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status == ST_DONE || rsp.status == ST_NOT_FOUND
                       || rsp.status == ST_FULL))
        else $error("undefined status code");

    // failed items report slot zero
    a_fail_pos: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_DONE |-> rsp.position == '0)
        else $error("nonzero position on a failed item");

    // full means the table holds DEPTH timers
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_FULL |-> rsp.entry_count == CNT_W'(DEPTH))
        else $error("full reported with a short table");

endmodule

bind sorted_timer_queue stq_checker #(.DEPTH(DEPTH)) u_stq_checker (.*);

>>> verif/tb_sorted_timer_queue.sv
// Testbench for the sorted timer queue: random and directed inserts/deletes against a predictor.
`timescale 1ns / 1ps

module tb_sorted_timer_queue;

    import stq_pkg::*;

    localparam int TIMER_SLOTS  = 16;
    localparam int QUIET_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 60;
    localparam int N_RANDOM     = 1330;
    localparam int HOLDOFF_AT   = 300;
    localparam int HOLDOFF_LEN  = 200;
    localparam int DRAIN_AT     = 700;
    localparam int CALM_FROM    = 900;
    localparam int CALM_TO      = 1100;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        req_t beat;
        bit   drain_first;
    } pending_req_t;

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    pending_req_t timer_requests[$];
    rsp_t         due_responses[$];

    // Predicted table contents
    entry_t      timer_table[TIMER_SLOTS];
    int unsigned timers_held;

    bit          req_beat     = 1'b0;
    int unsigned reqs_taken   = 0;
    int unsigned n_requests   = 0;
    int unsigned failures     = 0;
    int unsigned quiet_cycles = 0;
    int unsigned hold_left    = 0;
    bit          hold_done    = 1'b0;

    sorted_timer_queue #(.DEPTH(TIMER_SLOTS)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Expected result of one request; updates the predicted table
    function automatic rsp_t apply_timer_op(req_t r);
        rsp_t        res;
        int unsigned pos;
        int unsigned k;
        res = '0;
        pos = 0;
        if (r.mode == MODE_INSERT) begin
            if (timers_held >= TIMER_SLOTS) begin
                res.status      = ST_FULL;
                res.entry_count = CNT_W'(timers_held);
                return res;
            end
            // after every strictly earlier deadline, ahead of equal ones
            while (pos < timers_held && timer_table[pos].deadline < r.deadline)
                pos++;
            for (k = timers_held; k > pos; k--)
                timer_table[k] = timer_table[k - 1];
            timer_table[pos].deadline = r.deadline;
            timer_table[pos].timer_id = r.timer_id;
            timers_held++;
        end
        else begin
            while (pos < timers_held && timer_table[pos].timer_id != r.timer_id)
                pos++;
            if (pos >= timers_held) begin
                res.status      = ST_NOT_FOUND;
                res.entry_count = CNT_W'(timers_held);
                return res;
            end
            for (k = pos; k + 1 < timers_held; k++)
                timer_table[k] = timer_table[k + 1];
            timers_held--;
        end
        res.status      = ST_DONE;
        res.position    = POS_W'(pos);
        res.entry_count = CNT_W'(timers_held);
        return res;
    endfunction

    // Random idle decision, suppressed during the calm stretch
    function automatic bit idle_now();
        if (reqs_taken >= CALM_FROM && reqs_taken < CALM_TO)
            return 1'b0;
        return $urandom_range(99) < 36;
    endfunction

    task automatic queue_request(logic mode, logic [DL_W-1:0] dl, logic [ID_W-1:0] id,
                                 bit drain_first);
        pending_req_t p;
        p.beat.mode     = mode;
        p.beat.deadline = dl;
        p.beat.timer_id = id;
        p.drain_first   = drain_first;
        timer_requests.push_back(p);
        n_requests++;
    endtask

    // Sender: new beat at the falling edge, held until accepted
    always @(negedge clk)
    begin
        if (rst_n && !(req_valid && !req_beat)) begin
            if (timer_requests.size() != 0
                && !(timer_requests[0].drain_first && due_responses.size() != 0)
                && !idle_now()) begin
                req       <= timer_requests[0].beat;
                req_valid <= 1'b1;
                void'(timer_requests.pop_front());
            end
            else begin
                req_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off to back the block up
    always @(negedge clk)
    begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
        end
        else if (!hold_done && reqs_taken >= HOLDOFF_AT) begin
            hold_left <= HOLDOFF_LEN;
            hold_done <= 1'b1;
            rsp_ready <= 1'b0;
        end
        else begin
            rsp_ready <= !idle_now();
        end
    end

    // Monitor and watchdog, sampled at the rising edge
    always @(posedge clk)
    begin
        req_beat <= rst_n && req_valid && req_ready;
        if (rst_n) begin
            // check result first: it can never belong to a request taken on this edge
            if (rsp_valid && rsp_ready) begin
                if (due_responses.size() == 0) begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("%0t: unexpected result status=%0d pos=%0d count=%0d",
                                 $time, rsp.status, rsp.position, rsp.entry_count);
                end
                else begin
                    if (rsp.status !== due_responses[0].status
                        || rsp.position !== due_responses[0].position
                        || rsp.entry_count !== due_responses[0].entry_count) begin
                        failures++;
                        if (failures <= MAX_REPORTS)
                            $display("%0t: mismatch exp status=%0d pos=%0d count=%0d, got %0d %0d %0d",
                                     $time, due_responses[0].status, due_responses[0].position,
                                     due_responses[0].entry_count, rsp.status, rsp.position,
                                     rsp.entry_count);
                    end
                    void'(due_responses.pop_front());
                end
            end
            if (req_valid && req_ready) begin
                due_responses.push_back(apply_timer_op(req));
                reqs_taken++;
            end
            if ((rsp_valid && rsp_ready) || (req_valid && req_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int          i;
        int          phase;
        int unsigned ins_pct;
        logic [DL_W-1:0] dl;
        logic [ID_W-1:0] id;
        logic            mode;

        timers_held = 0;

        // Directed: empty table, fill with extremes and duplicates, full, deletes
        queue_request(MODE_DELETE, 32'h0000_0000, 8'h00, 1'b0);
        for (i = 0; i < TIMER_SLOTS; i++) begin
            if (i == 0 || i == 2)
                dl = '0;
            else if (i == 1)
                dl = '1;
            else if (i % 3 == 0)
                dl = 32'h8000_0000;
            else
                dl = $urandom;
            if (i == 1)
                id = 8'hFF;
            else if (i % 5 == 4)
                id = 8'h42;
            else
                id = ID_W'(i);
            queue_request(MODE_INSERT, dl, id, 1'b0);
        end
        queue_request(MODE_INSERT, 32'h0000_0005, 8'h77, 1'b0);  // table full
        queue_request(MODE_DELETE, 32'hFFFF_FFFF, 8'h99, 1'b0);  // absent id
        queue_request(MODE_DELETE, 32'h1234_5678, 8'h42, 1'b0);  // first of duplicates
        queue_request(MODE_DELETE, 32'h0000_0000, 8'hFF, 1'b0);  // latest deadline
        queue_request(MODE_DELETE, 32'hFFFF_FFFF, 8'h00, 1'b0);
        queue_request(MODE_INSERT, 32'h0000_0000, 8'h80, 1'b0);  // ahead of equal deadlines
        queue_request(MODE_DELETE, 32'h0000_0000, 8'h80, 1'b0);

        // Random: phases alternate between filling and draining the table
        for (i = 0; i < N_RANDOM; i++) begin
            phase = (i / 80) % 4;
            case (phase)
                0:       ins_pct = 75;
                1:       ins_pct = 50;
                2:       ins_pct = 25;
                default: ins_pct = 60;
            endcase
            mode = ($urandom_range(99) < ins_pct) ? MODE_INSERT : MODE_DELETE;
            // narrow ids so deletes usually hit
            id = ($urandom_range(99) < 75) ? ID_W'($urandom_range(15)) : ID_W'($urandom_range(255));
            case ($urandom_range(9))
                0, 1, 2, 3: dl = DL_W'($urandom_range(15));
                4:          dl = $urandom_range(1) ? '1 : '0;
                default:    dl = $urandom;
            endcase
            queue_request(mode, dl, id, i == 0 || i == DRAIN_AT);
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (reqs_taken < n_requests || due_responses.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (failures == 0 && due_responses.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sim.f
rtl/stq_pkg.sv
rtl/stq_store.sv
rtl/sorted_timer_queue.sv
rtl/stq_checker.sv
verif/tb_sorted_timer_queue.sv
